// ===== design/teq_pkg.sv =====
`default_nettype none
package teq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_PEEK  = 2'd1,
		OP_POP   = 2'd2,
		OP_RESET = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIV_LAT = 2'd0,
		DIV_Q   = 2'd1,
		DIV_R   = 2'd2
	} div_sel_t;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_RATE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 4'd1;
	localparam int CFG_DATA_W = 18;

	localparam logic [17:0] AUDIO_RATE_RST = 18'd48000;
	localparam logic [9:0]  TICK_RATE_RST  = 10'd60;

	localparam logic [19:0] US_PER_S  = 20'd1000000;
	localparam logic [19:0] HALF_S    = 20'd500000;
	localparam logic [19:0] MARGIN_US = 20'd3000;
	localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;
	// floor(2^49 / 10^6), reciprocal for dividing by US_PER_S
	localparam logic [29:0] RECIP_US  = 30'd562949953;

	localparam int DIV_N_W   = 49;
	localparam int DIV_D_W   = 20;
	localparam int DIV_STEPS = DIV_N_W;

	typedef struct packed {
		logic     idle;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul;
		logic     scan_init;
		logic     scan_rd;
		logic     move_rd;
		logic     move_wr;
		logic     push_wr;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic div_done;
		logic scan_empty;
		logic scan_last;
		logic found;
		logic full;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/teq_if.sv =====
`default_nettype none
interface teq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [47:0] time_us;
	logic [31:0] packet_in;
	logic [47:0] window_start;
	logic [47:0] window_end;
	logic [47:0] due_sample;
	modport source (output valid, op, time_us, packet_in, window_start, window_end,
		due_sample, input ready);
	modport sink (input valid, op, time_us, packet_in, window_start, window_end,
		due_sample, output ready);
endinterface

interface teq_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [47:0] evt_sample;
	logic [31:0] packet_out;
	logic        dropped;
	logic [8:0]  held;
	modport source (output valid, found, evt_sample, packet_out, dropped, held,
		input ready);
	modport sink (input valid, found, evt_sample, packet_out, dropped, held,
		output ready);
endinterface

interface teq_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [17:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/teq_div.sv =====
`default_nettype none
module teq_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [teq_pkg::DIV_N_W-1:0] dividend,
	input  logic [teq_pkg::DIV_D_W-1:0] divisor,
	output logic                       done,
	output logic [teq_pkg::DIV_N_W-1:0] quotient
);
	import teq_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [DIV_N_W-1:0]  dvd_q;
	logic [DIV_D_W-1:0]  dsr_q;
	logic [DIV_D_W-1:0]  rem_q;
	logic [DIV_D_W:0]    trial;
	logic [DIV_D_W:0]    diff;
	logic                take;

	// restoring, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[DIV_N_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign take  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			dvd_q <= {dvd_q[DIV_N_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

// ===== design/teq_ctrl.sv =====
`default_nettype none
module teq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  teq_pkg::sts_t sts,
	output teq_pkg::cmd_t cmd
);
	import teq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LAT,
		ST_LAT_W,
		ST_Q,
		ST_Q_W,
		ST_MUL,
		ST_R,
		ST_R_W,
		ST_SCAN0,
		ST_SCAN,
		ST_DRAIN,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_WRITE,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sts.in_valid) state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					case (sts.op)
						OP_PUSH: state_q <= ST_LAT;
						OP_PEEK: state_q <= ST_SCAN0;
						OP_POP:  state_q <= ST_SCAN0;
						default: state_q <= ST_FINISH;
					endcase
				end
				ST_LAT:   state_q <= ST_LAT_W;
				ST_LAT_W: begin
					if (sts.div_done) state_q <= ST_Q;
				end
				ST_Q:     state_q <= ST_Q_W;
				ST_Q_W: begin
					if (sts.div_done) state_q <= ST_MUL;
				end
				ST_MUL:   state_q <= ST_R;
				ST_R:     state_q <= ST_R_W;
				ST_R_W: begin
					if (sts.div_done) state_q <= sts.full ? ST_SCAN0 : ST_WRITE;
				end
				ST_SCAN0: state_q <= sts.scan_empty ? ST_FINISH : ST_SCAN;
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (sts.op == OP_PUSH) state_q <= ST_WRITE;
					else if (sts.op == OP_POP && sts.found) state_q <= ST_MOVE_RD;
					else state_q <= ST_FINISH;
				end
				ST_MOVE_RD: state_q <= ST_MOVE_WR;
				ST_MOVE_WR: state_q <= ST_FINISH;
				ST_WRITE:   state_q <= ST_FINISH;
				ST_FINISH: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_LAT;
		case (state_q)
			ST_IDLE:    cmd.idle = 1'b1;
			ST_LAT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_LAT;
			end
			ST_Q: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_Q;
			end
			ST_MUL:     cmd.mul = 1'b1;
			ST_R: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_R;
			end
			ST_SCAN0:   cmd.scan_init = 1'b1;
			ST_SCAN:    cmd.scan_rd = 1'b1;
			ST_MOVE_RD: cmd.move_rd = 1'b1;
			ST_MOVE_WR: cmd.move_wr = 1'b1;
			ST_WRITE:   cmd.push_wr = 1'b1;
			ST_FINISH:  cmd.finish = sts.out_free;
			default:    cmd.idle = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/teq_dp.sv =====
`default_nettype none
module teq_dp #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  teq_pkg::cmd_t cmd,
	output teq_pkg::sts_t sts,
	teq_req_if.sink       req,
	teq_rsp_if.source     rsp,
	teq_cfg_if.sink       cfg
);
	import teq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// captured transaction
	op_t         op_q;
	logic [47:0] now_q;
	logic [31:0] pkt_q;
	logic [47:0] ws_q;
	logic [47:0] we_q;
	logic [47:0] due_q;

	logic [47:0]   origin_q;
	logic [17:0]   sr_q;
	logic [9:0]    es_q;
	logic [CW-1:0] count_q;
	logic [31:0]   order_q;

	// stamp arithmetic
	div_sel_t    sel_q;
	logic [19:0] lat_q;
	logic [28:0] q_q;
	logic [19:0] r_q;
	logic        zero_q;
	logic [46:0] prod_q;
	logic [38:0] frac_q;
	logic [47:0] stamp_q;

	logic               div_done;
	logic [DIV_N_W-1:0] quot;
	logic [DIV_D_W-1:0] rem;

	logic               vd_start;
	logic               vd_done;
	logic [DIV_D_W-1:0] vd_divisor;
	logic [DIV_N_W-1:0] vd_quot;

	// divide by US_PER_S: reciprocal estimate, back-multiply, then fix-up
	logic        cd_start;
	logic [48:0] cd_x;
	logic [48:0] cd_x_q;
	logic        cd_v_s1;
	logic        cd_v_s2;
	logic        cd_v_s3;
	logic        cd_fix_q;
	logic [61:0] cd_est_c;
	logic [29:0] cd_est_s2;
	logic [49:0] cd_back_s3;
	logic [49:0] cd_diff_c;
	logic [29:0] cd_q_q;
	logic [21:0] cd_rem_q;
	logic        cd_done;

	logic [47:0]  fwd_c;
	logic [47:0]  back_c;
	logic [48:0]  us_c;
	logic         zero_c;
	logic [48:0]  sum_c;
	logic [46:0]  prod_c;
	logic [38:0]  frac_c;

	// storage and scan
	logic [47:0] mem_time   [QUEUE_DEPTH];
	logic [31:0] mem_order  [QUEUE_DEPTH];
	logic [31:0] mem_packet [QUEUE_DEPTH];

	logic [CW-1:0] scan_idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [47:0]   rd_time_s1;
	logic [31:0]   rd_order_s1;
	logic [31:0]   rd_pkt_s1;

	logic          best_found_q;
	logic [AW-1:0] best_idx_q;
	logic [47:0]   best_time_q;
	logic [31:0]   best_order_q;
	logic [31:0]   best_pkt_q;

	logic          full_c;
	logic [CW-1:0] limit_c;
	logic [CW-1:0] last_c;
	logic [AW-1:0] rd_addr;
	logic          qual_c;
	logic          before_c;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [47:0]   wr_time;
	logic [31:0]   wr_order;
	logic [31:0]   wr_pkt;
	logic [CW-1:0] count_n;
	logic          load;

	// result register
	logic        out_vld_q;
	logic        found_q;
	logic [47:0] esamp_q;
	logic [31:0] pout_q;
	logic        drop_q;
	logic [8:0]  held_q;

	assign load      = cmd.idle && req.valid;
	assign req.ready = cmd.idle;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q <= AUDIO_RATE_RST;
			es_q <= TICK_RATE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_AUDIO_RATE: sr_q <= cfg.data;
				CFG_TICK_RATE:  es_q <= cfg.data[9:0];
				default:        sr_q <= sr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= op_t'(req.op);
			now_q <= req.time_us;
			pkt_q <= req.packet_in;
			ws_q  <= req.window_start;
			we_q  <= req.window_end;
			due_q <= req.due_sample;
		end
	end

	// microseconds since origin plus latency; zero when before origin by at least the latency
	assign fwd_c  = now_q - origin_q;
	assign back_c = origin_q - now_q;
	always_comb begin
		zero_c = 1'b0;
		us_c   = '0;
		if (now_q >= origin_q) begin
			us_c = {1'b0, fwd_c} + 49'(lat_q);
		end else if (back_c >= 48'(lat_q)) begin
			zero_c = 1'b1;
		end else begin
			us_c = 49'(lat_q - back_c[19:0]);
		end
	end

	// latency term 10^6 / tick rate goes through the bit-serial divider
	assign vd_start   = cmd.div_start && cmd.div_sel == DIV_LAT;
	assign vd_divisor = (es_q == 10'd0) ? 20'd1 : 20'(es_q);

	teq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (vd_start),
		.dividend  (49'(US_PER_S)),
		.divisor   (vd_divisor),
		.done      (vd_done),
		.quotient  (vd_quot)
	);

	// estimate is low by at most two, so the fix-up loop runs 0 to 2 steps
	assign cd_start  = cmd.div_start && cmd.div_sel != DIV_LAT;
	assign cd_x      = (cmd.div_sel == DIV_Q) ? us_c : 49'(frac_q);
	assign cd_est_c  = 62'(cd_x_q[48:17]) * 62'(RECIP_US);
	assign cd_diff_c = {1'b0, cd_x_q} - cd_back_s3;
	assign cd_done   = cd_fix_q && cd_rem_q < 22'(US_PER_S);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_v_s1  <= 1'b0;
			cd_v_s2  <= 1'b0;
			cd_v_s3  <= 1'b0;
			cd_fix_q <= 1'b0;
		end else begin
			cd_v_s1 <= cd_start;
			cd_v_s2 <= cd_v_s1;
			cd_v_s3 <= cd_v_s2;
			if (cd_v_s3) cd_fix_q <= 1'b1;
			else if (cd_done) cd_fix_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cd_start) cd_x_q <= cd_x;
		cd_est_s2  <= cd_est_c[61:32];
		cd_back_s3 <= 50'(cd_est_s2) * 50'(US_PER_S);
		if (cd_v_s2) cd_q_q <= cd_est_s2;
		else if (cd_fix_q && !cd_done) cd_q_q <= cd_q_q + 30'd1;
		if (cd_v_s3) cd_rem_q <= cd_diff_c[21:0];
		else if (cd_fix_q && !cd_done) cd_rem_q <= cd_rem_q - 22'(US_PER_S);
	end

	assign div_done = vd_done || cd_done;
	assign quot     = (sel_q == DIV_LAT) ? vd_quot : 49'(cd_q_q);
	assign rem      = cd_rem_q[19:0];

	assign prod_c = 47'(q_q) * 47'(sr_q);
	assign frac_c = 39'(r_q) * 39'(sr_q) + 39'(HALF_S);
	assign sum_c  = {2'b00, prod_q} + quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= DIV_LAT;
		end else if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start && cmd.div_sel == DIV_Q) zero_q <= zero_c;
		if (cmd.mul) begin
			prod_q <= prod_c;
			frac_q <= frac_c;
		end
		if (div_done) begin
			case (sel_q)
				DIV_LAT: lat_q <= quot[19:0] + MARGIN_US;
				DIV_Q: begin
					q_q <= quot[28:0];
					r_q <= rem;
				end
				default: stamp_q <= zero_q ? 48'd0 : (sum_c[48] ? MAX48 : sum_c[47:0]);
			endcase
		end
	end

	// scan over stored entries, one read per cycle, compare in the cycle after the read
	assign full_c  = count_q == CW'(QUEUE_DEPTH);
	assign limit_c = (op_q == OP_PUSH) ? CW'(QUEUE_DEPTH) : count_q;
	assign last_c  = count_q - CW'(1);
	assign rd_addr = cmd.move_rd ? last_c[AW-1:0] : scan_idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		rd_time_s1  <= mem_time[rd_addr];
		rd_order_s1 <= mem_order[rd_addr];
		rd_pkt_s1   <= mem_packet[rd_addr];
		rd_idx_s1   <= scan_idx_q[AW-1:0];
	end

	always_comb begin
		case (op_q)
			OP_PEEK: qual_c = rd_time_s1 >= ws_q && rd_time_s1 < we_q;
			OP_POP:  qual_c = rd_time_s1 <= due_q;
			default: qual_c = 1'b1;
		endcase
	end

	assign before_c = (rd_time_s1 < best_time_q) ||
		(rd_time_s1 == best_time_q && rd_order_s1 < best_order_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_init) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) scan_idx_q <= scan_idx_q + CW'(1);
				if (rd_vld_s1 && qual_c && (!best_found_q || before_c))
					best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && qual_c && (!best_found_q || before_c)) begin
			best_idx_q   <= rd_idx_s1;
			best_time_q  <= rd_time_s1;
			best_order_q <= rd_order_s1;
			best_pkt_q   <= rd_pkt_s1;
		end
	end

	// push writes a new entry; pop moves the last entry into the freed slot
	assign wr_en = cmd.push_wr || cmd.move_wr;
	always_comb begin
		if (cmd.push_wr) begin
			wr_addr  = full_c ? best_idx_q : count_q[AW-1:0];
			wr_time  = stamp_q;
			wr_order = order_q;
			wr_pkt   = pkt_q;
		end else begin
			wr_addr  = best_idx_q;
			wr_time  = rd_time_s1;
			wr_order = rd_order_s1;
			wr_pkt   = rd_pkt_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_time[wr_addr]   <= wr_time;
			mem_order[wr_addr]  <= wr_order;
			mem_packet[wr_addr] <= wr_pkt;
		end
	end

	always_comb begin
		case (op_q)
			OP_PUSH:  count_n = full_c ? count_q : count_q + CW'(1);
			OP_POP:   count_n = best_found_q ? last_c : count_q;
			OP_RESET: count_n = '0;
			default:  count_n = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			order_q   <= '0;
			origin_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load && op_t'(req.op) == OP_PUSH && origin_q == 48'd0)
				origin_q <= req.time_us;
			if (cmd.finish) begin
				out_vld_q <= 1'b1;
				count_q   <= count_n;
				if (op_q == OP_PUSH) order_q <= order_q + 32'd1;
				if (op_q == OP_RESET) begin
					order_q  <= '0;
					origin_q <= now_q;
				end
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q <= (op_q == OP_PEEK || op_q == OP_POP) && best_found_q;
			esamp_q <= ((op_q == OP_PEEK || op_q == OP_POP) && best_found_q) ?
				best_time_q : 48'd0;
			pout_q  <= (op_q == OP_POP && best_found_q) ? best_pkt_q : 32'd0;
			drop_q  <= op_q == OP_PUSH && full_c;
			held_q  <= 9'(count_n);
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.found      = found_q;
	assign rsp.evt_sample = esamp_q;
	assign rsp.packet_out = pout_q;
	assign rsp.dropped    = drop_q;
	assign rsp.held       = held_q;

	assign sts.in_valid   = req.valid;
	assign sts.op         = op_q;
	assign sts.div_done   = div_done;
	assign sts.scan_empty = limit_c == '0;
	assign sts.scan_last  = (scan_idx_q + CW'(1)) == limit_c;
	assign sts.found      = best_found_q;
	assign sts.full       = full_c;
	assign sts.out_free   = !out_vld_q || rsp.ready;
endmodule
`default_nettype wire

// ===== design/timestamped_event_queue.sv =====
// Timestamped event queue.
// req carries one operation per transaction: push, peek, pop or reset, with the
// timer value, packet, peek window and due sample. rsp returns exactly one result
// per request: found, evt_sample, packet_out, dropped and held. cfg writes the
// audio sample rate (index 0) or the engine tick rate (index 1); it is always
// ready and should be used only while no request is in flight.
// One request is worked at a time; req.ready is high only while the controller
// is idle between requests. Peek and pop scan the held entries, and a pop that
// finds one moves the last entry into the freed slot. A push runs a 49-step
// bit-serial divide for the latency term, then two divides by 10^6 (reciprocal
// multiply, back-multiply, up to two fix-up steps), then a scan for the earliest
// entry when the queue is full. The scan reads one entry per cycle.
// The result sits in an output register; a stalled rsp holds it and the next
// request may be accepted and worked, finishing once the register is free.
// After arst_n the queue is empty, the origin is unset, the sequence count is
// zero and the rates hold 48000 and 60. Entry memory is not cleared.
`default_nettype none
module timestamped_event_queue #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	teq_req_if.sink   req,
	teq_rsp_if.source rsp,
	teq_cfg_if.sink   cfg
);
	import teq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	teq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	teq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

`ifndef SYNTHESIS
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp.valid) else $error("finished result not presented");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready) else $error("request taken while busy");
	a_drop_is_push: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.dropped) |-> (!rsp.found && rsp.packet_out == 32'd0))
		else $error("dropped flag on a non-push result");
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.div_start, cmd.scan_rd, cmd.push_wr, cmd.move_wr, cmd.finish}))
		else $error("conflicting datapath commands");
`endif
endmodule
`default_nettype wire

// ===== tb/timestamped_event_queue_checker.sv =====
`timescale 1ns / 1ps
module timestamped_event_queue_checker #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	teq_req_if   req,
	teq_rsp_if   rsp,
	teq_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	import teq_pkg::*;

	typedef struct {
		logic        found;
		logic [47:0] evt_sample;
		logic [31:0] packet_out;
		logic        dropped;
		logic [8:0]  held;
	} teq_result_t;

	teq_result_t result_q[$];

	logic [47:0] q_time[QUEUE_DEPTH];
	logic [31:0] q_order[QUEUE_DEPTH];
	logic [31:0] q_packet[QUEUE_DEPTH];
	int unsigned q_count;
	logic [31:0] seq_next;
	logic [47:0] origin;
	logic [17:0] rate;
	logic [9:0]  speed;

	assign pending = result_q.size();

	function automatic bit earlier(int a, int b);
		if (q_time[a] != q_time[b])
			return q_time[a] < q_time[b];
		return q_order[a] < q_order[b];
	endfunction

	function automatic logic [47:0] sample_of(logic [47:0] now);
		longint unsigned spd, lat, us, d, s;
		spd = (speed == 0) ? 1 : speed;
		lat = 64'd1000000 / spd + 64'd3000;
		if (now >= origin) begin
			us = longint'(now - origin) + lat;
		end else begin
			d = origin - now;
			if (d >= lat)
				return '0;
			us = lat - d;
		end
		s = (us / 64'd1000000) * rate + ((us % 64'd1000000) * rate + 64'd500000) / 64'd1000000;
		return (s > MAX48) ? MAX48 : s[47:0];
	endfunction

	function automatic teq_result_t apply_op(op_t op, logic [47:0] now, logic [31:0] pkt,
			logic [47:0] ws, logic [47:0] we, logic [47:0] due);
		teq_result_t r;
		int slot, best;
		r = '{1'b0, 48'd0, 32'd0, 1'b0, 9'd0};
		best = 0;
		case (op)
			OP_PUSH: begin
				if (origin == 0)
					origin = now;
				if (q_count < QUEUE_DEPTH) begin
					slot = q_count;
					q_count++;
				end else begin
					slot = 0;
					for (int i = 1; i < QUEUE_DEPTH; i++)
						if (earlier(i, slot))
							slot = i;
					r.dropped = 1'b1;
				end
				q_time[slot] = sample_of(now);
				q_order[slot] = seq_next;
				q_packet[slot] = pkt;
				seq_next++;
			end
			OP_PEEK: begin
				for (int i = 0; i < q_count; i++) begin
					if (q_time[i] < ws || q_time[i] >= we)
						continue;
					if (!r.found || earlier(i, best)) begin
						r.found = 1'b1;
						best = i;
					end
				end
				if (r.found)
					r.evt_sample = q_time[best];
			end
			OP_POP: begin
				for (int i = 0; i < q_count; i++) begin
					if (q_time[i] > due)
						continue;
					if (!r.found || earlier(i, best)) begin
						r.found = 1'b1;
						best = i;
					end
				end
				if (r.found) begin
					r.evt_sample = q_time[best];
					r.packet_out = q_packet[best];
					q_count--;
					if (best < q_count) begin
						q_time[best] = q_time[q_count];
						q_order[best] = q_order[q_count];
						q_packet[best] = q_packet[q_count];
					end
				end
			end
			default: begin
				origin = now;
				q_count = 0;
				seq_next = '0;
			end
		endcase
		r.held = q_count[8:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		teq_result_t exp_r;
		if (!arst_n) begin
			q_count = 0;
			seq_next = '0;
			origin = '0;
			rate = AUDIO_RATE_RST;
			speed = TICK_RATE_RST;
			errors = 0;
			result_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_AUDIO_RATE)
					rate = cfg.data;
				else if (cfg.index == CFG_TICK_RATE)
					speed = cfg.data[9:0];
			end
			if (req.valid && req.ready)
				result_q.push_back(apply_op(op_t'(req.op), req.time_us, req.packet_in,
					req.window_start, req.window_end, req.due_sample));
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected response transaction at %0t", $realtime);
					errors = errors + 1;
				end else begin
					exp_r = result_q.pop_front();
					if (rsp.found !== exp_r.found || rsp.evt_sample !== exp_r.evt_sample ||
							rsp.packet_out !== exp_r.packet_out ||
							rsp.dropped !== exp_r.dropped || rsp.held !== exp_r.held) begin
						if (errors < 10) begin
							$write("mismatch at %0t: exp found=%0d sample=%0d pkt=%h ",
								$realtime, exp_r.found, exp_r.evt_sample, exp_r.packet_out);
							$write("drop=%0d held=%0d, got found=%0d sample=%0d ",
								exp_r.dropped, exp_r.held, rsp.found, rsp.evt_sample);
							$display("pkt=%h drop=%0d held=%0d",
								rsp.packet_out, rsp.dropped, rsp.held);
						end
						errors = errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/timestamped_event_queue_tb.sv =====
`timescale 1ns / 1ps
module timestamped_event_queue_tb;
	import teq_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   burst_left;
	logic [47:0] base;

	teq_req_if req ();
	teq_rsp_if rsp ();
	teq_cfg_if cfg ();

	timestamped_event_queue dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	timestamped_event_queue_checker chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg), .errors(errors), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("timestamped_event_queue test failed");
		$finish;
	end

	// response stall pattern: a random ready mode is held for each random-length span
	initial begin
		int mode, span;
		rsp.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(100, 600);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= $urandom_range(0, 1);
					2: rsp.ready <= ($urandom_range(0, 9) == 0);
					default: rsp.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic send(op_t op, logic [47:0] t, logic [31:0] pkt, logic [47:0] ws,
			logic [47:0] we, logic [47:0] due);
		bit acc;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.time_us <= t;
		req.packet_in <= pkt;
		req.window_start <= ws;
		req.window_end <= we;
		req.due_sample <= due;
		do begin
			@(negedge clk);
			acc = req.ready;
			@(posedge clk);
		end while (!acc);
		burst_left--;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [17:0] val);
		bit acc;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do begin
			@(negedge clk);
			acc = cfg.ready;
			@(posedge clk);
		end while (!acc);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [47:0] pick_time();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return rand48();
		if (k == 1)
			return base - 48'($urandom_range(0, 400000));
		return base + 48'($urandom_range(0, 3000000));
	endfunction

	task automatic random_items(int n);
		int k;
		logic [47:0] ws;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			ws = 48'($urandom_range(0, 800000));
			if (k < 42) begin
				send(OP_PUSH, pick_time(), $urandom(), rand48(), rand48(), rand48());
			end else if (k < 62) begin
				case ($urandom_range(0, 9))
					0: send(OP_PEEK, rand48(), $urandom(), rand48(), rand48(), rand48());
					1: send(OP_PEEK, rand48(), $urandom(), ws,
						ws - 48'($urandom_range(0, 9999)), rand48());
					default: send(OP_PEEK, rand48(), $urandom(), ws,
						ws + 48'($urandom_range(0, 300000)), rand48());
				endcase
			end else if (k < 97) begin
				case ($urandom_range(0, 9))
					0: send(OP_POP, rand48(), $urandom(), rand48(), rand48(), MAX48);
					1: send(OP_POP, rand48(), $urandom(), rand48(), rand48(), rand48());
					default: send(OP_POP, rand48(), $urandom(), rand48(), rand48(),
						48'($urandom_range(0, 900000)));
				endcase
			end else begin
				base = rand48() >> $urandom_range(0, 20);
				send(OP_RESET, base, $urandom(), rand48(), rand48(), rand48());
			end
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.op = OP_PUSH;
		req.time_us = '0;
		req.packet_in = '0;
		req.window_start = '0;
		req.window_end = '0;
		req.due_sample = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_AUDIO_RATE;
		cfg.data = '0;
		burst_left = 0;
		base = 48'd1000;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unset origin, empty queue, pre-origin times, window edges
		send(OP_RESET, 48'd0, 32'd0, 48'd0, 48'd0, 48'd0);
		send(OP_PEEK, 48'd0, 32'd0, 48'd0, MAX48, 48'd0);
		send(OP_POP, 48'd0, 32'd0, 48'd0, 48'd0, MAX48);
		send(OP_PUSH, 48'd1000, 32'h0000_0000, 48'd0, 48'd0, 48'd0);
		send(OP_PUSH, 48'd1000, 32'hFFFF_FFFF, MAX48, MAX48, MAX48);
		send(OP_PUSH, 48'd0, 32'h1234_5678, 48'd0, 48'd0, 48'd0);
		send(OP_PUSH, MAX48, 32'hA5A5_5A5A, 48'd0, 48'd0, 48'd0);
		send(OP_PEEK, 48'd0, 32'd0, 48'd0, MAX48, 48'd0);
		send(OP_PEEK, 48'd0, 32'd0, 48'd500, 48'd100, 48'd0);
		send(OP_PEEK, 48'd0, 32'd0, 48'd200, 48'd200, 48'd0);
		send(OP_PEEK, 48'd0, 32'd0, 48'd1, MAX48, 48'd0);
		send(OP_POP, 48'd0, 32'd0, 48'd0, 48'd0, 48'd0);
		send(OP_POP, 48'd0, 32'd0, 48'd0, 48'd0, 48'd200);
		send(OP_POP, 48'd0, 32'd0, 48'd0, 48'd0, MAX48);
		send(OP_POP, 48'd0, 32'd0, 48'd0, 48'd0, MAX48);
		send(OP_POP, 48'd0, 32'd0, 48'd0, 48'd0, MAX48);
		send(OP_RESET, 48'd5000, 32'd0, 48'd0, 48'd0, 48'd0);
		send(OP_PUSH, 48'd4000, 32'hCAFE_0001, 48'd0, 48'd0, 48'd0);
		send(OP_PUSH, 48'd4000, 32'hCAFE_0002, 48'd0, 48'd0, 48'd0);
		send(OP_POP, 48'd0, 32'd0, 48'd0, 48'd0, MAX48);
		drain();

		// fill past depth so pushes overwrite the earliest entry
		base = 48'd77_000_000;
		send(OP_RESET, base, 32'd0, 48'd0, 48'd0, 48'd0);
		for (int i = 0; i < 300; i++)
			send(OP_PUSH, pick_time(), $urandom(), 48'd0, 48'd0, 48'd0);
		for (int i = 0; i < 40; i++)
			send(OP_PEEK, 48'd0, 32'd0, 48'($urandom_range(0, 200000)), MAX48, 48'd0);
		random_items(60);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_AUDIO_RATE, 18'd0);
					write_reg(CFG_TICK_RATE, 18'd0);
				end
				1: begin
					write_reg(CFG_AUDIO_RATE, 18'h3FFFF);
					write_reg(CFG_TICK_RATE, 18'h3FF);
				end
				2: begin
					write_reg(CFG_AUDIO_RATE, 18'd8000);
					write_reg(CFG_TICK_RATE, 18'd1000);
				end
				3: begin
					write_reg(CFG_AUDIO_RATE, 18'd192000);
					write_reg(CFG_TICK_RATE, 18'd1);
				end
				4: begin
					write_reg(CFG_AUDIO_RATE, 18'd44100);
					write_reg(CFG_TICK_RATE, 18'h3FC00 | 18'd60);
				end
				default: begin
					write_reg(CFG_AUDIO_RATE, 18'($urandom()));
					write_reg(CFG_TICK_RATE, 18'($urandom()));
				end
			endcase
			base = rand48() >> $urandom_range(4, 24);
			send(OP_RESET, base, $urandom(), rand48(), rand48(), rand48());
			random_items(240);
			drain();
		end

		if (errors == 0)
			$display("timestamped_event_queue test passed");
		else
			$display("timestamped_event_queue test failed");
		$finish;
	end
endmodule
